### design/itsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itsl_pkg
// Shared types and constants for the interval table block.
// ----------------------------------------------------------------------------
package itsl_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int COORD_BITS = 32;
  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS = IDX_BITS + 1;
  localparam int ENTRY_BITS = 2 * COORD_BITS + 1;
  // sort counters: gap can run to about three times the table depth
  localparam int GAP_BITS = CNT_BITS + 1;
  // ceil(2^(GAP_BITS+1) / 3), exact floor divide by 3 below 2^GAP_BITS
  localparam int GAP_RECIP = (2 ** (GAP_BITS + 1) + 2) / 3;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_SORT  = 3'd2;
  localparam logic [2:0] OP_POINT = 3'd3;
  localparam logic [2:0] OP_RANGE = 3'd4;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_c;
    logic [COORD_BITS-1:0] end_c;
    logic                  strand;
  } entry_t;
endpackage

### design/itsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itsl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module itsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/interval_table_sort_and_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_sort_and_lookup
// Interval table with shell sort and binary-search point and range queries.
// ----------------------------------------------------------------------------
// One request at a time through a single-port table RAM and a sequencer.
// Clear resets the entry count and load writes one entry at the count. A query
// reads one table entry per binary-search probe, and a range query may also
// read the left neighbour of a candidate. Sort reads and compares entry pairs,
// writes them back swapped when out of order, and steps back along the lane.
// tready is low while a request runs or a result waits.
module interval_table_sort_and_lookup (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[2:0], entry_start[34:3], entry_end[66:35], entry_strand[67],
  // query_low[99:68], query_high[131:100], zero fill to 136
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], hit_index[10:1], hit_start[42:11], hit_end[74:43],
  // hit_strand[75], status[76], zero fill to 80
  output logic [79:0]  m_tdata
);
  import itsl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOADW, S_GAPUP, S_SHELL, S_LANE, S_POS, S_RDA, S_RDB, S_CMP,
    S_WRA, S_WRB, S_BACK, S_BRD, S_BCMP, S_BWR, S_BWR2, S_QPROBE, S_QRD,
    S_QCMP, S_QPRV, S_QPCMP, S_OUT
  } state_t;

  state_t state;
  logic [2:0] op;
  logic [COORD_BITS-1:0] ql, qh;
  entry_t ld;
  logic [CNT_BITS-1:0] count;
  logic [GAP_BITS-1:0] gap, lane, pos, back, cur, last;
  logic signed [CNT_BITS:0] lo, hi;
  logic [IDX_BITS-1:0] mid;
  entry_t ea, eb;
  logic we;
  logic [IDX_BITS-1:0] addr;
  entry_t wdata, rdata;
  logic found, status;
  logic [IDX_BITS-1:0] hidx;
  entry_t hent;
  logic [CNT_BITS+1:0] mid_sum;
  logic [GAP_BITS:0] pos_fwd;
  logic [2*GAP_BITS-1:0] gap_prod;

  itsl_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign pos_fwd = {1'b0, pos} + {1'b0, gap};
  // next smaller Knuth gap, (gap - 1) / 3
  assign gap_prod = (2*GAP_BITS)'(gap - 1'b1) * (2*GAP_BITS)'(GAP_RECIP);

  always_comb begin
    we = 1'b0;
    addr = '0;
    wdata = ea;
    unique case (state)
      S_LOADW: begin
        we = 1'b1; addr = count[IDX_BITS-1:0]; wdata = ld;
      end
      S_RDA:  addr = pos[IDX_BITS-1:0];
      S_RDB:  addr = pos_fwd[IDX_BITS-1:0];
      S_WRA:  begin we = 1'b1; addr = pos[IDX_BITS-1:0]; wdata = eb; end
      S_WRB:  begin we = 1'b1; addr = pos_fwd[IDX_BITS-1:0]; wdata = ea; end
      S_BRD:  addr = back[IDX_BITS-1:0];
      S_BWR:  begin we = 1'b1; addr = cur[IDX_BITS-1:0]; wdata = ea; end
      S_BWR2: begin we = 1'b1; addr = back[IDX_BITS-1:0]; wdata = eb; end
      S_QRD:  addr = mid;
      S_QPRV: addr = mid - 1'b1;
      default: addr = '0;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {3'b0, status, hent.strand, hent.end_c, hent.start_c, hidx, found};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[2:0];
            ql <= s_tdata[99:68];
            qh <= s_tdata[131:100];
            ld.strand <= s_tdata[67];
            if (s_tdata[66:35] < s_tdata[34:3]) begin
              ld.start_c <= s_tdata[66:35]; ld.end_c <= s_tdata[34:3];
            end else begin
              ld.start_c <= s_tdata[34:3]; ld.end_c <= s_tdata[66:35];
            end
            found <= 1'b0; hidx <= '0; hent <= '0;
            status <= (s_tdata[2:0] == OP_LOAD) && (count == CNT_BITS'(TABLE_DEPTH));
            lo <= '0;
            hi <= $signed({1'b0, count} - 1'b1);
            last <= {1'b0, count} - 1'b1;
            gap <= GAP_BITS'(1);
            unique case (s_tdata[2:0])
              OP_CLEAR: begin count <= '0; state <= S_OUT; end
              OP_LOAD: state <= (count == CNT_BITS'(TABLE_DEPTH)) ? S_OUT : S_LOADW;
              OP_SORT: state <= (count >= CNT_BITS'(2)) ? S_GAPUP : S_OUT;
              OP_POINT, OP_RANGE: state <= S_QPROBE;
              default: state <= S_OUT;
            endcase
          end
        end
        S_LOADW: begin count <= count + 1'b1; state <= S_OUT; end
        S_GAPUP: if (gap + 1'b1 < last) begin
          gap <= {gap[GAP_BITS-2:0], 1'b0} + gap + 1'b1;
        end else begin
          state <= S_SHELL;
        end
        S_SHELL: if (gap == '0) state <= S_OUT;
                 else begin lane <= '0; state <= S_LANE; end
        S_LANE: if (lane > gap) begin
          gap <= {1'b0, gap_prod[2*GAP_BITS-1:GAP_BITS+1]}; state <= S_SHELL;
        end else begin
          pos <= lane; state <= S_POS;
        end
        S_POS: if (pos_fwd <= {1'b0, last}) state <= S_RDA;
               else begin lane <= lane + 1'b1; state <= S_LANE; end
        S_RDA: state <= S_RDB;
        S_RDB: begin ea <= rdata; state <= S_CMP; end
        S_CMP: begin
          eb <= rdata;
          if (ea.start_c > rdata.start_c) state <= S_WRA;
          else begin pos <= pos_fwd[GAP_BITS-1:0]; state <= S_POS; end
        end
        S_WRA: state <= S_WRB;
        S_WRB: begin back <= pos; cur <= pos; state <= S_BACK; end
        S_BACK: if (back >= gap) begin
          back <= back - gap; state <= S_BRD;
        end else begin
          pos <= pos_fwd[GAP_BITS-1:0]; state <= S_POS;
        end
        S_BRD: state <= S_BCMP;
        S_BCMP: begin
          // eb is the entry being moved down; rdata is the entry at back
          if (eb.start_c > rdata.start_c) begin
            pos <= pos_fwd[GAP_BITS-1:0]; state <= S_POS;
          end else begin
            ea <= rdata; state <= S_BWR;
          end
        end
        S_BWR: state <= S_BWR2;
        S_BWR2: begin cur <= back; state <= S_BACK; end
        S_QPROBE: if (lo <= hi) begin
          mid <= mid_sum[IDX_BITS:1]; state <= S_QRD;
        end else state <= S_OUT;
        S_QRD: state <= S_QCMP;
        S_QCMP: begin
          if (((op == OP_POINT) ? ql : qh) < rdata.start_c) begin
            hi <= $signed({2'b0, mid} - 1'b1); state <= S_QPROBE;
          end else if (ql > rdata.end_c) begin
            lo <= $signed({2'b0, mid} + 1'b1); state <= S_QPROBE;
          end else if (op == OP_POINT || mid == '0) begin
            found <= 1'b1; hidx <= mid; hent <= rdata; state <= S_OUT;
          end else begin
            ea <= rdata; state <= S_QPRV;
          end
        end
        S_QPRV: state <= S_QPCMP;
        S_QPCMP: begin
          // rdata holds the left neighbour of the candidate
          if (ql > rdata.end_c) begin
            found <= 1'b1; hidx <= mid; hent <= ea; state <= S_OUT;
          end else begin
            hi <= $signed({2'b0, mid} - 1'b1); state <= S_QPROBE;
          end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid));
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid);
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata));
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(TABLE_DEPTH));
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !found |-> hidx == '0 && hent == '0);
`endif
endmodule

### dv/tb_interval_table_sort_and_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_table_sort_and_lookup
// Self-checking testbench for the interval table sort and lookup block.
// ----------------------------------------------------------------------------
// Requests go in over the slave stream with random gaps. A local copy of the
// table predicts each answer: loads, shell sort with Knuth gaps, and
// binary-search point and range lookups. Each answer on the master stream is
// compared field by field with the oldest prediction. The receiver stalls at
// random, and once holds off for a long stretch while loads keep coming.
// ----------------------------------------------------------------------------
module tb_interval_table_sort_and_lookup;
  import itsl_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic        found;
    logic [9:0]  hit_index;
    logic [31:0] hit_start;
    logic [31:0] hit_end;
    logic        hit_strand;
    logic        status;
  } answer_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;

  logic [31:0] tbl_start [TABLE_DEPTH];
  logic [31:0] tbl_end [TABLE_DEPTH];
  logic        tbl_strand [TABLE_DEPTH];
  int          tbl_count;

  answer_t     pending_answers[$];
  int          errors;
  int          hold_cycles;
  bit          no_idle;

  interval_table_sort_and_lookup u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  task automatic swap_rows(input int a, input int b);
    logic [31:0] t;
    logic s;
    t = tbl_start[a]; tbl_start[a] = tbl_start[b]; tbl_start[b] = t;
    t = tbl_end[a]; tbl_end[a] = tbl_end[b]; tbl_end[b] = t;
    s = tbl_strand[a]; tbl_strand[a] = tbl_strand[b]; tbl_strand[b] = s;
  endtask

  task automatic shell_sort_table();
    int last, gap, lane, pos, back, cur;
    if (tbl_count < 2) return;
    last = tbl_count - 1;
    gap = 1;
    while (gap < last - 1) gap = 3 * gap + 1;
    while (gap > 0) begin
      for (lane = 0; lane <= gap; lane++) begin
        for (pos = lane; pos + gap <= last; pos += gap) begin
          if (tbl_start[pos] > tbl_start[pos + gap]) begin
            swap_rows(pos, pos + gap);
            back = pos;
            cur = pos;
            while (back >= gap) begin
              back -= gap;
              if (tbl_start[cur] > tbl_start[back]) break;
              swap_rows(cur, back);
              cur = back;
            end
          end
        end
      end
      gap = (gap - 1) / 3;
    end
  endtask

  function automatic int find_point(input logic [31:0] q);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (q < tbl_start[mid]) hi = mid - 1;
      else if (q > tbl_end[mid]) lo = mid + 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic int find_overlap(input logic [31:0] a, input logic [31:0] b);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (b < tbl_start[mid]) hi = mid - 1;
      else if (a > tbl_end[mid]) lo = mid + 1;
      else if (mid == 0) return mid;
      else if (a > tbl_end[mid - 1]) return mid;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  task automatic apply_request(input logic [2:0] op, input logic [31:0] es,
                               input logic [31:0] ee, input logic est,
                               input logic [31:0] ql, input logic [31:0] qh);
    answer_t ans;
    int hit;
    ans = '0;
    hit = -1;
    case (op)
      OP_CLEAR: tbl_count = 0;
      OP_LOAD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          ans.status = 1'b1;
        end else begin
          tbl_start[tbl_count] = (ee < es) ? ee : es;
          tbl_end[tbl_count] = (ee < es) ? es : ee;
          tbl_strand[tbl_count] = est;
          tbl_count++;
        end
      end
      OP_SORT: shell_sort_table();
      OP_POINT: hit = find_point(ql);
      OP_RANGE: hit = find_overlap(ql, qh);
      default: ;
    endcase
    if (hit >= 0) begin
      ans.found = 1'b1;
      ans.hit_index = hit[9:0];
      ans.hit_start = tbl_start[hit];
      ans.hit_end = tbl_end[hit];
      ans.hit_strand = tbl_strand[hit];
    end
    pending_answers.push_back(ans);
  endtask

  task automatic send_request(input logic [2:0] op, input logic [31:0] es = 0,
                              input logic [31:0] ee = 0, input logic est = 0,
                              input logic [31:0] ql = 0, input logic [31:0] qh = 0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata = {4'd0, qh, ql, est, ee, es, op};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(op, es, ee, est, ql, qh);
  endtask

  function automatic logic [31:0] rand_coord(input bit narrow);
    return narrow ? 32'($urandom_range(0, 200)) : 32'($urandom);
  endfunction

  task automatic send_random_query(input bit narrow);
    logic [31:0] a, b;
    a = rand_coord(narrow);
    b = ($urandom_range(0, 3) == 0) ? rand_coord(narrow) : a + $urandom_range(0, 30);
    send_request($urandom_range(0, 1) ? OP_POINT : OP_RANGE, $urandom, $urandom,
                 1'($urandom), a, b);
  endtask

  task automatic test_directed();
    send_request(OP_POINT, 0, 0, 0, 5, 5);
    send_request(OP_RANGE, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_request(OP_SORT);
    send_request(OP_LOAD, 32'd100, 32'd50, 1'b1);
    send_request(OP_SORT);
    send_request(OP_POINT, 0, 0, 0, 32'd75, 0);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
    send_request(OP_LOAD, 32'd0, 32'd0, 1'b1);
    send_request(OP_LOAD, 32'd60, 32'd200, 1'b0);
    send_request(OP_LOAD, 32'd60, 32'd70, 1'b1);
    send_request(OP_POINT, 0, 0, 0, 32'd65, 0);
    send_request(OP_SORT);
    send_request(OP_POINT, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_request(OP_POINT, 0, 0, 0, 32'd0, 0);
    send_request(OP_POINT, 0, 0, 0, 32'd300, 0);
    send_request(OP_RANGE, 0, 0, 0, 32'd65, 32'd80);
    send_request(OP_RANGE, 0, 0, 0, 32'd300, 32'd10);
    send_request(OP_RANGE, 0, 0, 0, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SPARE_B);
    send_request(OP_SPARE_C);
    send_request(OP_CLEAR);
    send_request(OP_RANGE, 0, 0, 0, 32'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_tables();
    int n;
    bit narrow;
    for (int round = 0; round < 14; round++) begin
      no_idle = (round % 5 == 3);
      narrow = $urandom_range(0, 3) != 0;
      n = $urandom_range(0, 4) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 40);
      send_request(OP_CLEAR);
      repeat (n) begin
        send_request(OP_LOAD, rand_coord(narrow), rand_coord(narrow), 1'($urandom));
      end
      if ($urandom_range(0, 5) != 0) send_request(OP_SORT);
      repeat ($urandom_range(4, 10)) send_random_query(narrow);
      if ($urandom_range(0, 9) == 0) send_request(3'($urandom_range(5, 7)));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_table();
    send_request(OP_CLEAR);
    hold_cycles = 400;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 500) no_idle = 1'b1;
      if (i == 600) no_idle = 1'b0;
      send_request(OP_LOAD, $urandom, $urandom, 1'($urandom));
    end
    send_request(OP_LOAD, 32'd1, 32'd2, 1'b1);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_request(OP_SORT);
    repeat (20) send_random_query(1'b0);
    for (int i = 0; i < 5; i++) begin
      send_request(OP_POINT, 0, 0, 0, tbl_start[$urandom_range(0, TABLE_DEPTH - 1)], 0);
    end
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int k;
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      k = no_idle ? 0 : $urandom_range(0, 12);
      if (k > 0) begin
        m_tready = 1'b0;
        repeat (k) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      answer_t got, want;
      got.found = m_tdata[0];
      got.hit_index = m_tdata[10:1];
      got.hit_start = m_tdata[42:11];
      got.hit_end = m_tdata[74:43];
      got.hit_strand = m_tdata[75];
      got.status = m_tdata[76];
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
          errors++;
        end
        if (got.hit_index !== want.hit_index) begin
          $display("%0t: hit_index exp %0d got %0d", $time, want.hit_index, got.hit_index);
          errors++;
        end
        if (got.hit_start !== want.hit_start) begin
          $display("%0t: hit_start exp %h got %h", $time, want.hit_start, got.hit_start);
          errors++;
        end
        if (got.hit_end !== want.hit_end) begin
          $display("%0t: hit_end exp %h got %h", $time, want.hit_end, got.hit_end);
          errors++;
        end
        if (got.hit_strand !== want.hit_strand) begin
          $display("%0t: hit_strand exp %0d got %0d", $time, want.hit_strand,
                   got.hit_strand);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    errors = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    tbl_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_tables();
    test_full_table();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
